>>> hdl/bba_pkg.sv
// Shared constants, types and codes of the buddy block allocator.
package bba_pkg;

	localparam int POOL_ORDER = 10;
	localparam int ADDR_W     = POOL_ORDER;
	localparam int DEPTH      = 1 << POOL_ORDER;
	localparam int NUM_ORD    = POOL_ORDER + 1;
	localparam int ORD_W      = $clog2(NUM_ORD);
	localparam int WORDS_W    = 11;
	localparam int NEED_W     = WORDS_W + 1;
	localparam int STAT_W     = 2;
	localparam int S_DATA_W   = 24;
	localparam int S_USER_W   = 1;
	localparam int M_DATA_W   = 16;
	localparam int M_USER_W   = STAT_W;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ORD_W-1:0]  ord_t;
	typedef logic [NEED_W-1:0] need_t;

	typedef struct packed {
		logic  tag;
		ord_t  order;
		addr_t prev;
		addr_t next;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef enum logic [STAT_W-1:0] {
		RES_OK   = 2'd0,
		RES_SIZE = 2'd1,
		RES_FULL = 2'd2
	} status_e;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_e;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE,
		S_A_HDR, S_A_PRW, S_A_NXR, S_A_NXW, S_A_SPLIT, S_A_TAG,
		S_F_ORD, S_F_CHK, S_F_BUD, S_F_NXW, S_F_PRR, S_F_PRW, S_F_MRR, S_F_MRW,
		S_F_PUSH, S_F_FST, S_F_LR, S_F_LW, S_F_FR, S_F_FW,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_ACCEPT, OP_DECODE,
		OP_A_HDR, OP_A_PRW, OP_A_NXR, OP_A_NXW, OP_A_SPLIT, OP_A_TAGR, OP_A_TAG,
		OP_F_ORD, OP_F_CHK, OP_F_BUD, OP_F_NXW, OP_F_PRR, OP_F_PRW, OP_F_MRR, OP_F_MRW,
		OP_F_PUSH, OP_F_FST, OP_F_LR, OP_F_LW, OP_F_FR, OP_F_FW,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic words_zero;
		logic found;
		logic nx_eq_pa;
		logic split_more;
		logic at_top;
		logic has_buddy;
		logic buddy_ok;
		logic head_valid_k;
		logic out_free;
	} stat_t;

endpackage

>>> hdl/bba_ram.sv
// Generic single-port RAM with registered read.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hdl/bba_ctrl.sv
// Controller state machine that sequences allocate and free operations.
module bba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bba_pkg::stat_t st,
	output bba_pkg::cmd_t  cmd
);

	bba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::S_IDLE:    if (in_valid) state_d = bba_pkg::S_DECODE;
			bba_pkg::S_DECODE: begin
				if (st.is_free) state_d = bba_pkg::S_F_ORD;
				else if (st.words_zero || !st.found) state_d = bba_pkg::S_DONE;
				else state_d = bba_pkg::S_A_HDR;
			end
			bba_pkg::S_A_HDR:   state_d = st.nx_eq_pa ? bba_pkg::S_A_SPLIT : bba_pkg::S_A_PRW;
			bba_pkg::S_A_PRW:   state_d = bba_pkg::S_A_NXR;
			bba_pkg::S_A_NXR:   state_d = bba_pkg::S_A_NXW;
			bba_pkg::S_A_NXW:   state_d = bba_pkg::S_A_SPLIT;
			bba_pkg::S_A_SPLIT: if (!st.split_more) state_d = bba_pkg::S_A_TAG;
			bba_pkg::S_A_TAG:   state_d = bba_pkg::S_DONE;
			bba_pkg::S_F_ORD:   state_d = bba_pkg::S_F_CHK;
			bba_pkg::S_F_CHK: begin
				state_d = (st.at_top || !st.has_buddy) ? bba_pkg::S_F_PUSH : bba_pkg::S_F_BUD;
			end
			bba_pkg::S_F_BUD:   state_d = st.buddy_ok ? bba_pkg::S_F_NXW : bba_pkg::S_F_PUSH;
			bba_pkg::S_F_NXW:   state_d = bba_pkg::S_F_PRR;
			bba_pkg::S_F_PRR:   state_d = bba_pkg::S_F_PRW;
			bba_pkg::S_F_PRW:   state_d = bba_pkg::S_F_MRR;
			bba_pkg::S_F_MRR:   state_d = bba_pkg::S_F_MRW;
			bba_pkg::S_F_MRW:   state_d = bba_pkg::S_F_CHK;
			bba_pkg::S_F_PUSH:  state_d = st.head_valid_k ? bba_pkg::S_F_FST : bba_pkg::S_DONE;
			bba_pkg::S_F_FST:   state_d = bba_pkg::S_F_LR;
			bba_pkg::S_F_LR:    state_d = bba_pkg::S_F_LW;
			bba_pkg::S_F_LW:    state_d = bba_pkg::S_F_FR;
			bba_pkg::S_F_FR:    state_d = bba_pkg::S_F_FW;
			bba_pkg::S_F_FW:    state_d = bba_pkg::S_DONE;
			bba_pkg::S_DONE:    if (st.out_free) state_d = bba_pkg::S_IDLE;
			default:            state_d = bba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == bba_pkg::S_IDLE);
		cmd.op   = bba_pkg::OP_NOP;
		unique case (state_q)
			bba_pkg::S_IDLE:    cmd.op = in_valid ? bba_pkg::OP_ACCEPT : bba_pkg::OP_NOP;
			bba_pkg::S_DECODE:  cmd.op = bba_pkg::OP_DECODE;
			bba_pkg::S_A_HDR:   cmd.op = bba_pkg::OP_A_HDR;
			bba_pkg::S_A_PRW:   cmd.op = bba_pkg::OP_A_PRW;
			bba_pkg::S_A_NXR:   cmd.op = bba_pkg::OP_A_NXR;
			bba_pkg::S_A_NXW:   cmd.op = bba_pkg::OP_A_NXW;
			bba_pkg::S_A_SPLIT: cmd.op = st.split_more ? bba_pkg::OP_A_SPLIT : bba_pkg::OP_A_TAGR;
			bba_pkg::S_A_TAG:   cmd.op = bba_pkg::OP_A_TAG;
			bba_pkg::S_F_ORD:   cmd.op = bba_pkg::OP_F_ORD;
			bba_pkg::S_F_CHK: begin
				cmd.op = (st.at_top || !st.has_buddy) ? bba_pkg::OP_NOP : bba_pkg::OP_F_CHK;
			end
			bba_pkg::S_F_BUD:   cmd.op = st.buddy_ok ? bba_pkg::OP_F_BUD : bba_pkg::OP_NOP;
			bba_pkg::S_F_NXW:   cmd.op = bba_pkg::OP_F_NXW;
			bba_pkg::S_F_PRR:   cmd.op = bba_pkg::OP_F_PRR;
			bba_pkg::S_F_PRW:   cmd.op = bba_pkg::OP_F_PRW;
			bba_pkg::S_F_MRR:   cmd.op = bba_pkg::OP_F_MRR;
			bba_pkg::S_F_MRW:   cmd.op = bba_pkg::OP_F_MRW;
			bba_pkg::S_F_PUSH:  cmd.op = bba_pkg::OP_F_PUSH;
			bba_pkg::S_F_FST:   cmd.op = bba_pkg::OP_F_FST;
			bba_pkg::S_F_LR:    cmd.op = bba_pkg::OP_F_LR;
			bba_pkg::S_F_LW:    cmd.op = bba_pkg::OP_F_LW;
			bba_pkg::S_F_FR:    cmd.op = bba_pkg::OP_F_FR;
			bba_pkg::S_F_FW:    cmd.op = bba_pkg::OP_F_FW;
			bba_pkg::S_DONE:    cmd.op = bba_pkg::OP_DONE;
			default:            cmd.op = bba_pkg::OP_NOP;
		endcase
	end

endmodule

>>> hdl/bba_dp.sv
// Datapath with header memory, free list heads and the result register.
module bba_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::cmd_t                 cmd,
	output bba_pkg::stat_t                st,
	input  logic [bba_pkg::S_DATA_W-1:0]  in_data,
	input  logic [bba_pkg::S_USER_W-1:0]  in_user,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bba_pkg::M_DATA_W-1:0]  out_data,
	output logic [bba_pkg::M_USER_W-1:0]  out_user
);

	localparam bba_pkg::hdr_t RESET_HDR = '{
		tag: 1'b0, order: bba_pkg::ORD_W'(bba_pkg::POOL_ORDER), prev: '0, next: '0};

	bba_pkg::command_e cmd_q;
	bba_pkg::need_t    need_q;
	bba_pkg::addr_t    p_q, pa_q, b_q, pr_q, nx_q, first_q, last_q;
	bba_pkg::ord_t     k_q, j_q;
	logic              head_v_q [bba_pkg::NUM_ORD];
	bba_pkg::addr_t    head_a_q [bba_pkg::NUM_ORD];
	logic              init0_q, rd0_q;
	bba_pkg::status_e  res_status_q;
	bba_pkg::addr_t    res_addr_q;
	bba_pkg::ord_t     res_order_q;
	logic              m_valid_q;
	bba_pkg::status_e  m_status_q;
	bba_pkg::addr_t    m_addr_q;
	bba_pkg::ord_t     m_order_q;

	logic                      ram_we;
	bba_pkg::addr_t            ram_addr;
	bba_pkg::hdr_t             ram_wdata;
	logic [bba_pkg::HDR_W-1:0] ram_rdata;
	bba_pkg::hdr_t             hdr_rd;

	logic           found;
	bba_pkg::ord_t  found_k;
	bba_pkg::ord_t  jm1;
	bba_pkg::addr_t pi, m_sz, mask2, low, b_next;
	logic           split_more, at_top, has_buddy, out_free;

	bba_ram #(.WIDTH(bba_pkg::HDR_W), .DEPTH(bba_pkg::DEPTH)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign hdr_rd = rd0_q ? RESET_HDR : bba_pkg::hdr_t'(ram_rdata);

	always_comb begin
		found   = 1'b0;
		found_k = '0;
		for (int i = bba_pkg::NUM_ORD - 1; i >= 0; i--) begin
			if (head_v_q[i] && ((bba_pkg::NEED_W'(1) << i) >= need_q)) begin
				found   = 1'b1;
				found_k = bba_pkg::ORD_W'(i);
			end
		end
	end

	assign jm1        = j_q - bba_pkg::ORD_W'(1);
	assign split_more = (j_q != '0) && ((bba_pkg::NEED_W'(1) << jm1) >= need_q);
	assign pi         = pa_q + (bba_pkg::ADDR_W'(1) << jm1);
	assign at_top     = (k_q >= bba_pkg::ORD_W'(bba_pkg::POOL_ORDER));
	assign m_sz       = bba_pkg::ADDR_W'(1) << k_q;
	assign mask2      = (m_sz << 1) - bba_pkg::ADDR_W'(1);
	assign low        = p_q & mask2;
	assign has_buddy  = (low == '0) || (low == m_sz);
	assign b_next     = (low == '0) ? (p_q + m_sz) : (p_q - m_sz);
	assign out_free   = !m_valid_q || out_ready;

	always_comb begin
		st.is_free      = (cmd_q == bba_pkg::CMD_FREE);
		st.words_zero   = (need_q == bba_pkg::NEED_W'(1));
		st.found        = found;
		st.nx_eq_pa     = (hdr_rd.next == pa_q);
		st.split_more   = split_more;
		st.at_top       = at_top;
		st.has_buddy    = has_buddy;
		st.buddy_ok     = !hdr_rd.tag && (hdr_rd.order == k_q);
		st.head_valid_k = head_v_q[k_q];
		st.out_free     = out_free;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = p_q;
		ram_wdata = hdr_rd;
		unique case (cmd.op)
			bba_pkg::OP_DECODE: begin
				ram_addr = (cmd_q == bba_pkg::CMD_FREE) ? p_q : head_a_q[found_k];
			end
			bba_pkg::OP_A_HDR:  ram_addr = hdr_rd.prev;
			bba_pkg::OP_A_PRW: begin
				ram_we         = 1'b1;
				ram_addr       = pr_q;
				ram_wdata.next = nx_q;
			end
			bba_pkg::OP_A_NXR:  ram_addr = nx_q;
			bba_pkg::OP_A_NXW: begin
				ram_we         = 1'b1;
				ram_addr       = nx_q;
				ram_wdata.prev = pr_q;
			end
			bba_pkg::OP_A_SPLIT: begin
				ram_we    = 1'b1;
				ram_addr  = pi;
				ram_wdata = '{tag: 1'b0, order: jm1, prev: pi, next: pi};
			end
			bba_pkg::OP_A_TAGR: ram_addr = pa_q;
			bba_pkg::OP_A_TAG: begin
				ram_we          = 1'b1;
				ram_addr        = pa_q;
				ram_wdata.tag   = 1'b1;
				ram_wdata.order = j_q;
			end
			bba_pkg::OP_F_CHK:  ram_addr = b_next;
			bba_pkg::OP_F_BUD:  ram_addr = hdr_rd.next;
			bba_pkg::OP_F_NXW: begin
				ram_we         = 1'b1;
				ram_addr       = nx_q;
				ram_wdata.prev = pr_q;
			end
			bba_pkg::OP_F_PRR:  ram_addr = pr_q;
			bba_pkg::OP_F_PRW: begin
				ram_we         = 1'b1;
				ram_addr       = pr_q;
				ram_wdata.next = nx_q;
			end
			bba_pkg::OP_F_MRR:  ram_addr = p_q;
			bba_pkg::OP_F_MRW: begin
				ram_we          = 1'b1;
				ram_addr        = p_q;
				ram_wdata.tag   = 1'b0;
				ram_wdata.order = k_q + bba_pkg::ORD_W'(1);
			end
			bba_pkg::OP_F_PUSH: begin
				if (head_v_q[k_q]) begin
					ram_addr = head_a_q[k_q];
				end else begin
					ram_we    = 1'b1;
					ram_addr  = p_q;
					ram_wdata = '{tag: 1'b0, order: k_q, prev: p_q, next: p_q};
				end
			end
			bba_pkg::OP_F_FST: begin
				ram_we    = 1'b1;
				ram_addr  = p_q;
				ram_wdata = '{tag: 1'b0, order: k_q, prev: hdr_rd.prev, next: first_q};
			end
			bba_pkg::OP_F_LR:   ram_addr = last_q;
			bba_pkg::OP_F_LW: begin
				ram_we         = 1'b1;
				ram_addr       = last_q;
				ram_wdata.next = p_q;
			end
			bba_pkg::OP_F_FR:   ram_addr = first_q;
			bba_pkg::OP_F_FW: begin
				ram_we         = 1'b1;
				ram_addr       = first_q;
				ram_wdata.prev = p_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0_q <= 1'b1;
			rd0_q   <= 1'b0;
			for (int i = 0; i < bba_pkg::NUM_ORD; i++) begin
				head_v_q[i] <= (i == bba_pkg::POOL_ORDER);
				head_a_q[i] <= '0;
			end
			m_valid_q <= 1'b0;
		end else begin
			rd0_q <= init0_q && !ram_we && (ram_addr == '0);
			if (ram_we && (ram_addr == '0)) begin
				init0_q <= 1'b0;
			end
			unique case (cmd.op)
				bba_pkg::OP_A_HDR: begin
					if (hdr_rd.next == pa_q) head_v_q[k_q] <= 1'b0;
					else head_a_q[k_q] <= hdr_rd.next;
				end
				bba_pkg::OP_A_SPLIT: begin
					head_v_q[jm1] <= 1'b1;
					head_a_q[jm1] <= pi;
				end
				bba_pkg::OP_F_PRW: begin
					if (head_v_q[k_q] && (head_a_q[k_q] == b_q)) begin
						if (nx_q == b_q) head_v_q[k_q] <= 1'b0;
						else head_a_q[k_q] <= nx_q;
					end
				end
				bba_pkg::OP_F_PUSH: begin
					if (!head_v_q[k_q]) begin
						head_v_q[k_q] <= 1'b1;
						head_a_q[k_q] <= p_q;
					end
				end
				bba_pkg::OP_F_FW: begin
					head_v_q[k_q] <= 1'b1;
					head_a_q[k_q] <= p_q;
				end
				default: ;
			endcase
			if (m_valid_q && out_ready) begin
				m_valid_q <= 1'b0;
			end
			if ((cmd.op == bba_pkg::OP_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bba_pkg::OP_ACCEPT: begin
				cmd_q        <= bba_pkg::command_e'(in_user[0]);
				need_q       <= bba_pkg::NEED_W'(in_data[bba_pkg::WORDS_W-1:0]) +
					bba_pkg::NEED_W'(1);
				p_q          <= in_data[bba_pkg::WORDS_W+bba_pkg::ADDR_W-1:bba_pkg::WORDS_W];
				res_status_q <= bba_pkg::RES_OK;
				res_addr_q   <= '0;
				res_order_q  <= '0;
			end
			bba_pkg::OP_DECODE: begin
				if (cmd_q == bba_pkg::CMD_ALLOC) begin
					if (need_q == bba_pkg::NEED_W'(1)) begin
						res_status_q <= bba_pkg::RES_SIZE;
					end else if (!found) begin
						res_status_q <= bba_pkg::RES_FULL;
					end else begin
						k_q  <= found_k;
						j_q  <= found_k;
						pa_q <= head_a_q[found_k];
					end
				end
			end
			bba_pkg::OP_A_HDR, bba_pkg::OP_F_BUD: begin
				nx_q <= hdr_rd.next;
				pr_q <= hdr_rd.prev;
			end
			bba_pkg::OP_A_SPLIT: j_q <= jm1;
			bba_pkg::OP_A_TAG: begin
				res_addr_q  <= pa_q;
				res_order_q <= j_q;
			end
			bba_pkg::OP_F_ORD: begin
				k_q <= (hdr_rd.order > bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) ?
					bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) : hdr_rd.order;
			end
			bba_pkg::OP_F_CHK:  b_q <= b_next;
			bba_pkg::OP_F_PRW:  if (b_q < p_q) p_q <= b_q;
			bba_pkg::OP_F_MRW:  k_q <= k_q + bba_pkg::ORD_W'(1);
			bba_pkg::OP_F_PUSH: first_q <= head_a_q[k_q];
			bba_pkg::OP_F_FST:  last_q <= hdr_rd.prev;
			bba_pkg::OP_DONE: begin
				if (out_free) begin
					m_status_q <= res_status_q;
					m_addr_q   <= res_addr_q;
					m_order_q  <= res_order_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = m_valid_q;
	assign out_user  = m_status_q;
	assign out_data  = bba_pkg::M_DATA_W'({m_order_q, m_addr_q});

endmodule

>>> hdl/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: controller, datapath and stream ports.
//
// The block manages a pool of 2^10 units as a buddy system. Each input word on the
// s_axis channel carries a command in tuser (allocate or free) and the request size
// and block address in tdata. Every input word produces exactly one result word on
// m_axis: the status in tuser and the granted address and order in tdata.
// One item is worked at a time. A grant relinks the list neighbors of the taken
// block when it has any, then splits off one half per step until the block fits;
// a free merges with its buddy, level by level, while the buddy is free and of
// the same order, and then puts the block at the head of its free list. These
// steps are sequenced because the single-port header memory serves one read or
// one write per cycle.
// After reset the pool is one free block of order 10 at unit 0 and the block is
// ready at once; no clearing pass is needed. The result sits in an output register,
// so a new word is taken while a result still waits; the block holds its finished
// next result until the receiver takes the waiting one.
module buddy_block_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// request_words [10:0], block_address [20:11], zero padding above
	input  logic [bba_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// command [0]
	input  logic [bba_pkg::S_USER_W-1:0]  s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// granted_address [9:0], granted_order [13:10], zero padding above
	output logic [bba_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// status [1:0]
	output logic [bba_pkg::M_USER_W-1:0]  m_axis_tuser
);

	bba_pkg::cmd_t  cmd;
	bba_pkg::stat_t st;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

>>> hdl/bba_checker.sv
// Port-level checker for the buddy block allocator and its bind statement.
module bba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [bba_pkg::S_DATA_W-1:0]  s_axis_tdata,
	input logic [bba_pkg::S_USER_W-1:0]  s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bba_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input logic [bba_pkg::M_USER_W-1:0]  m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word taken while busy");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == bba_pkg::RES_OK) ||
			(m_axis_tuser == bba_pkg::RES_SIZE) || (m_axis_tuser == bba_pkg::RES_FULL))
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != bba_pkg::RES_OK) |-> (m_axis_tdata == '0))
		else $error("error result carries a grant");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[bba_pkg::ADDR_W+bba_pkg::ORD_W-1:bba_pkg::ADDR_W] <=
			bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)))
		else $error("granted order above pool order");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);
